FILE: sv/sbscd_pkg.sv
package sbscd_pkg;

  typedef logic signed [63:0] word_t;

  // Post-product shift for the shared multiplier
  typedef enum logic [1:0] {
    SH15 = 2'd0,
    SH30 = 2'd1,
    SH31 = 2'd2,
    SH44 = 2'd3
  } shsel_e;

  typedef struct packed {
    logic   go;
    word_t  a;
    word_t  b;
    shsel_e sh;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } mul_rsp_t;

  typedef struct packed {
    logic        go;
    logic [31:0] trim_from;
    logic [31:0] trim_to;
    logic [15:0] n;
    logic [15:0] len;
  } trim_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] trim;
  } trim_rsp_t;

  typedef struct packed {
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] left_out;
    logic signed [31:0] right_out;
  } out_beat_t;

  localparam logic [2:0] CFG_FADER  = 3'd0;
  localparam logic [2:0] CFG_BLOCK  = 3'd1;
  localparam logic [2:0] CFG_FILTER = 3'd2;
  localparam logic [2:0] CFG_A0     = 3'd3;
  localparam logic [2:0] CFG_B1     = 3'd4;
  localparam logic [2:0] CFG_B2     = 3'd5;
  localparam logic [2:0] CFG_SEED_L = 3'd6;
  localparam logic [2:0] CFG_SEED_R = 3'd7;

  localparam logic [31:0] SEED_L_RST = 32'd16386;
  localparam logic [31:0] SEED_R_RST = 32'd24601;
  localparam logic [28:0] DITHER_K   = 29'd490616394;
  localparam logic [31:0] NOISE_MID  = 32'h7fffffff;

  // Q4.44 constants, decimal scaled by 2^44 with rounding
  localparam word_t HALF_PI = ((64'd157079633 / 64'd390625) << 36)
    + ((((64'd157079633 % 64'd390625) << 36) + 64'd195312) / 64'd390625);
  localparam word_t CK_A = ((64'd70582080 / 64'd390625) << 36)
    + ((((64'd70582080 % 64'd390625) << 36) + 64'd195312) / 64'd390625);
  localparam word_t CK_B = ((64'd26091480 / 64'd390625) << 36)
    + ((((64'd26091480 % 64'd390625) << 36) + 64'd195312) / 64'd390625);
  localparam word_t CK_C = ((64'd24917170 / 64'd390625) << 36)
    + ((((64'd24917170 % 64'd390625) << 36) + 64'd195312) / 64'd390625);
  localparam word_t CK_D = ((64'd73908510 / 64'd390625) << 36)
    + ((((64'd73908510 % 64'd390625) << 36) + 64'd195312) / 64'd390625);
  localparam word_t CK_T = ((64'd9549925859 / 64'd9765625) << 34)
    + ((((64'd9549925859 % 64'd9765625) << 34) + 64'd4882812) / 64'd9765625);
  localparam word_t FOUR = 64'sd4 <<< 44;

  localparam word_t SC0 = ((64'd1 << 44) + 64'd6227020800 / 64'd2) / 64'd6227020800;
  localparam word_t SC1 = -(((64'd1 << 44) + 64'd39916800 / 64'd2) / 64'd39916800);
  localparam word_t SC2 = ((64'd1 << 44) + 64'd362880 / 64'd2) / 64'd362880;
  localparam word_t SC3 = -(((64'd1 << 44) + 64'd5040 / 64'd2) / 64'd5040);
  localparam word_t SC4 = ((64'd1 << 44) + 64'd120 / 64'd2) / 64'd120;
  localparam word_t SC5 = -(((64'd1 << 44) + 64'd6 / 64'd2) / 64'd6);
  localparam word_t SC6 = 64'sd1 <<< 44;

endpackage

FILE: sv/stereo_bus_saturate_clip_dither_core.sv
// Channel  | Signals                             | Beat
// ---------+-------------------------------------+------------------------------
// input    | in_valid_i, in_ready_o, in_beat_i   | one stereo pair, Q3.28
// output   | out_valid_o, out_ready_i, out_beat_o| one stereo pair, Q1.30
// config   | cfg_we_i, cfg_idx_i, cfg_data_i     | one register write, no wait
//
// A pair runs through the one-bit-per-cycle trim divider, then per channel
// 10 to 18 products through the shared four-pass 32x32 multiplier, plus a
// leading-one scan for the dither exponent.
// in_ready_o is high only while the sequencer is idle; a finished pair waits
// in the output register and the next pair is taken meanwhile.
// Reset sets the ramp trims to one half, clears filter, clipper and block
// state, and loads the default dither seeds.
module stereo_bus_saturate_clip_dither_core import sbscd_pkg::*; #(
  parameter int IntW = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_beat_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [63:0] MaxMag = (64'd1 << (IntW - 1)) - 64'd1;
  localparam word_t PosMax = $signed(MaxMag);
  localparam word_t NegMax = -$signed(MaxMag);

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_TGO   = 20'h00002,
    ST_TWAIT = 20'h00004,
    ST_PRE   = 20'h00008,
    ST_SQ    = 20'h00010,
    ST_POLY  = 20'h00020,
    ST_SINX  = 20'h00040,
    ST_F1    = 20'h00080,
    ST_F2    = 20'h00100,
    ST_F3    = 20'h00200,
    ST_F4    = 20'h00400,
    ST_TRIM2 = 20'h00800,
    ST_CP    = 20'h01000,
    ST_CPV   = 20'h02000,
    ST_CN    = 20'h04000,
    ST_CNV   = 20'h08000,
    ST_DSET  = 20'h10000,
    ST_NORM  = 20'h20000,
    ST_DMUL  = 20'h40000,
    ST_DOUT  = 20'h80000
  } state_e;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [64:0] s;
    word_t r;
    s = 65'(a) + 65'(b);
    if (s > 65'(PosMax)) r = PosMax;
    else if (s < 65'(NegMax)) r = NegMax;
    else r = s[63:0];
    return r;
  endfunction

  function automatic word_t sin_coef(logic [2:0] k);
    word_t c;
    unique case (k)
      3'd0:    c = SC0;
      3'd1:    c = SC1;
      3'd2:    c = SC2;
      3'd3:    c = SC3;
      3'd4:    c = SC4;
      3'd5:    c = SC5;
      default: c = SC6;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] xorshift(logic [31:0] r);
    logic [31:0] x;
    x = r ^ (r << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [16:0] fader_q;
  logic [15:0] blen_q;
  logic        fen_q;
  logic [30:0] a0_q;
  logic [31:0] b1_q, b2_q;

  // block ramp
  logic [31:0] trim_start_q, trim_end_q;
  logic [15:0] frames_q, n_q, len_q;
  logic [31:0] trim_q;

  // per-channel state
  logic signed [IntW-1:0] held_q [2];
  logic signed [IntW-1:0] s1_q   [2];
  logic signed [IntW-1:0] s2_q   [2];
  logic [31:0]            noise_q[2];
  logic [3:0]             flags_q;

  // working registers
  in_beat_t    in_q;
  logic        ch_q;
  logic        pend_q;
  word_t       x_q, t_q, s_q, v_q, p1_q, p2_q, o_q, y_q;
  logic [2:0]  k_q;
  logic [63:0] m_q;
  logic [5:0]  cnt_q;
  logic [6:0]  sh_q;
  logic [60:0] p_q;
  logic        rneg_q;
  logic [31:0] left_res_q;
  out_beat_t   out_q;
  logic        out_valid_q;

  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  trim_req_t trim_req;
  trim_rsp_t trim_rsp;

  logic        op_need;
  word_t       hv, s1v, s2v, raw;
  logic        cp_lt, cn_gt;
  logic [1:0]  pbit, nbit;
  logic [15:0] len_eff, fl_cur, fl_new;
  logic [31:0] fader_trim;
  logic signed [32:0] r_dith;
  logic [31:0] r_mag;
  word_t       d_mag, d_val, y_sum, y_shr;
  logic [31:0] out_word;
  logic        out_load;

  always_comb begin
    hv    = word_t'(held_q[ch_q]);
    s1v   = word_t'(s1_q[ch_q]);
    s2v   = word_t'(s2_q[ch_q]);
    raw   = ch_q ? word_t'(in_q.right_in) : word_t'(in_q.left_in);
    cp_lt = (v_q < hv);
    cn_gt = (v_q > hv);
    pbit  = {ch_q, 1'b0};
    nbit  = {ch_q, 1'b1};

    len_eff    = (blen_q == 16'd0) ? 16'd1 : blen_q;
    fl_cur     = (frames_q == 16'd0) ? len_eff : frames_q;
    fl_new     = fl_cur - 16'd1;
    fader_trim = (fader_q >= 17'd65536) ? 32'hffffffff : {fader_q[15:0], 16'd0};

    r_dith = $signed({1'b0, noise_q[ch_q]}) - $signed({1'b0, NOISE_MID});
    r_mag  = r_dith[32] ? 32'(-r_dith) : r_dith[31:0];
    d_mag  = (sh_q >= 7'd64) ? 64'sd0 : $signed(64'(p_q >> sh_q[5:0]));
    d_val  = rneg_q ? -d_mag : d_mag;
    y_sum  = sat_add(y_q, d_val);
    y_shr  = y_sum >>> 14;
    if (y_shr > 64'sh7fffffff) out_word = 32'h7fffffff;
    else if (y_shr < -64'sh80000000) out_word = 32'h80000000;
    else out_word = y_shr[31:0];

    // load the finished pair once the output register is free
    out_load = (state_q == ST_DOUT) && ch_q && (!out_valid_q || out_ready_i);
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_req.a  = '0;
    mul_req.b  = '0;
    mul_req.sh = SH44;
    op_need    = 1'b1;
    unique case (state_q)
      ST_PRE: begin
        mul_req.a = raw; mul_req.b = {32'd0, trim_q}; mul_req.sh = SH15;
      end
      ST_SQ:   begin mul_req.a = x_q; mul_req.b = x_q; end
      ST_POLY: begin mul_req.a = t_q; mul_req.b = s_q; end
      ST_SINX: begin mul_req.a = x_q; mul_req.b = s_q; end
      ST_F1: begin
        mul_req.a = v_q; mul_req.b = {33'd0, a0_q}; mul_req.sh = SH30;
      end
      ST_F2: begin
        mul_req.a = v_q; mul_req.b = {32'd0, a0_q, 1'b0}; mul_req.sh = SH30;
      end
      ST_F3: begin
        mul_req.a = o_q; mul_req.b = word_t'($signed(b1_q)); mul_req.sh = SH30;
      end
      ST_F4: begin
        mul_req.a = o_q; mul_req.b = word_t'($signed(b2_q)); mul_req.sh = SH30;
      end
      ST_TRIM2: begin
        mul_req.a = v_q; mul_req.b = {32'd0, trim_q}; mul_req.sh = SH31;
      end
      ST_CP: begin
        mul_req.a = cp_lt ? v_q : hv;
        mul_req.b = cp_lt ? CK_B : CK_D;
        op_need   = flags_q[pbit];
      end
      ST_CPV: begin
        mul_req.a = hv; mul_req.b = CK_B; op_need = (v_q > CK_T);
      end
      ST_CN: begin
        mul_req.a = cn_gt ? v_q : hv;
        mul_req.b = cn_gt ? CK_B : CK_D;
        op_need   = flags_q[nbit];
      end
      ST_CNV: begin
        mul_req.a = hv; mul_req.b = CK_B; op_need = (v_q < -CK_T);
      end
      default: op_need = 1'b0;
    endcase
    mul_req.go = op_need && !pend_q;
  end

  always_comb begin
    trim_req.go        = (state_q == ST_TGO);
    trim_req.trim_from = trim_start_q;
    trim_req.trim_to   = trim_end_q;
    trim_req.n         = n_q;
    trim_req.len       = len_q;
  end

  sbscd_mul #(.IntW(IntW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  sbscd_trim_div u_trim (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trim_req),
    .rsp_o  (trim_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_TGO;
      ST_TGO:   state_d = ST_TWAIT;
      ST_TWAIT: if (trim_rsp.done) state_d = ST_PRE;
      ST_PRE:   if (mul_rsp.done) state_d = ST_SQ;
      ST_SQ:    if (mul_rsp.done) state_d = ST_POLY;
      ST_POLY:  if (mul_rsp.done && k_q == 3'd6) state_d = ST_SINX;
      ST_SINX:  if (mul_rsp.done) state_d = fen_q ? ST_F1 : ST_TRIM2;
      ST_F1:    if (mul_rsp.done) state_d = ST_F2;
      ST_F2:    if (mul_rsp.done) state_d = ST_F3;
      ST_F3:    if (mul_rsp.done) state_d = ST_F4;
      ST_F4:    if (mul_rsp.done) state_d = ST_TRIM2;
      ST_TRIM2: if (mul_rsp.done) state_d = ST_CP;
      ST_CP:    if (!op_need || mul_rsp.done) state_d = ST_CPV;
      ST_CPV:   if (!op_need || mul_rsp.done) state_d = ST_CN;
      ST_CN:    if (!op_need || mul_rsp.done) state_d = ST_CNV;
      ST_CNV:   if (!op_need || mul_rsp.done) state_d = ST_DSET;
      ST_DSET:  state_d = ST_NORM;
      ST_NORM:  if (m_q == 64'd0 || m_q[63]) state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DOUT;
      ST_DOUT: begin
        if (!ch_q) state_d = ST_PRE;
        else if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fader_q      <= 17'd32768;
      blen_q       <= 16'd64;
      fen_q        <= 1'b0;
      a0_q         <= '0;
      b1_q         <= '0;
      b2_q         <= '0;
      trim_start_q <= 32'h40000000;
      trim_end_q   <= 32'h40000000;
      frames_q     <= '0;
      n_q          <= '0;
      len_q        <= 16'd1;
      trim_q       <= '0;
      held_q       <= '{default: '0};
      s1_q         <= '{default: '0};
      s2_q         <= '{default: '0};
      noise_q[0]   <= SEED_L_RST;
      noise_q[1]   <= SEED_R_RST;
      flags_q      <= '0;
      in_q         <= '0;
      ch_q         <= 1'b0;
      pend_q       <= 1'b0;
      x_q          <= '0;
      t_q          <= '0;
      s_q          <= '0;
      v_q          <= '0;
      p1_q         <= '0;
      p2_q         <= '0;
      o_q          <= '0;
      y_q          <= '0;
      k_q          <= '0;
      m_q          <= '0;
      cnt_q        <= '0;
      sh_q         <= '0;
      p_q          <= '0;
      rneg_q       <= 1'b0;
      left_res_q   <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FADER:  fader_q    <= cfg_data_i[16:0];
          CFG_BLOCK:  blen_q     <= cfg_data_i[15:0];
          CFG_FILTER: fen_q      <= cfg_data_i[0];
          CFG_A0:     a0_q       <= cfg_data_i[30:0];
          CFG_B1:     b1_q       <= cfg_data_i;
          CFG_B2:     b2_q       <= cfg_data_i;
          CFG_SEED_L: noise_q[0] <= cfg_data_i;
          CFG_SEED_R: noise_q[1] <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      // issue a product; pend_q stays set until its result lands
      if (mul_req.go) pend_q <= 1'b1;
      if (mul_rsp.done) pend_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            in_q <= in_beat_i;
            if (frames_q == 16'd0) begin
              trim_start_q <= trim_end_q;
              trim_end_q   <= fader_trim;
            end
            frames_q <= fl_new;
            n_q      <= (fl_new > len_eff) ? len_eff : fl_new;
            len_q    <= len_eff;
          end
        end
        ST_TGO: ;
        ST_TWAIT: begin
          if (trim_rsp.done) begin
            trim_q <= trim_rsp.trim;
            ch_q   <= 1'b0;
          end
        end
        ST_PRE: begin
          if (mul_rsp.done) begin
            if (mul_rsp.res > HALF_PI) x_q <= HALF_PI;
            else if (mul_rsp.res < -HALF_PI) x_q <= -HALF_PI;
            else x_q <= mul_rsp.res;
          end
        end
        ST_SQ: begin
          if (mul_rsp.done) begin
            t_q <= mul_rsp.res;
            s_q <= sin_coef(3'd0);
            k_q <= 3'd1;
          end
        end
        ST_POLY: begin
          if (mul_rsp.done) begin
            s_q <= sat_add(sin_coef(k_q), mul_rsp.res);
            k_q <= k_q + 3'd1;
          end
        end
        ST_SINX: if (mul_rsp.done) v_q <= mul_rsp.res;
        ST_F1: begin
          if (mul_rsp.done) begin
            p1_q <= mul_rsp.res;
            o_q  <= sat_add(mul_rsp.res, s1v);
          end
        end
        ST_F2: if (mul_rsp.done) p2_q <= mul_rsp.res;
        ST_F3: begin
          if (mul_rsp.done) begin
            s1_q[ch_q] <= IntW'(sat_add(sat_add(p2_q, -mul_rsp.res), s2v));
          end
        end
        ST_F4: begin
          if (mul_rsp.done) begin
            s2_q[ch_q] <= IntW'(sat_add(p1_q, -mul_rsp.res));
            v_q        <= o_q;
          end
        end
        ST_TRIM2: begin
          if (mul_rsp.done) begin
            if (mul_rsp.res > FOUR) v_q <= FOUR;
            else if (mul_rsp.res < -FOUR) v_q <= -FOUR;
            else v_q <= mul_rsp.res;
          end
        end
        ST_CP: begin
          // positive hysteresis: relax the held value, then drop the flag
          if (op_need && mul_rsp.done) begin
            held_q[ch_q]  <= IntW'(sat_add(cp_lt ? CK_A : CK_C, mul_rsp.res));
            flags_q[pbit] <= 1'b0;
          end
        end
        ST_CPV: begin
          if (op_need && mul_rsp.done) begin
            flags_q[pbit] <= 1'b1;
            v_q           <= sat_add(CK_A, mul_rsp.res);
          end
        end
        ST_CN: begin
          if (op_need && mul_rsp.done) begin
            held_q[ch_q]  <= IntW'(sat_add(cn_gt ? -CK_A : -CK_C, mul_rsp.res));
            flags_q[nbit] <= 1'b0;
          end
        end
        ST_CNV: begin
          if (op_need && mul_rsp.done) begin
            flags_q[nbit] <= 1'b1;
            v_q           <= sat_add(-CK_A, mul_rsp.res);
          end
        end
        ST_DSET: begin
          // one-sample delay: emit the held value, hold the new one
          y_q           <= hv;
          held_q[ch_q]  <= v_q[IntW-1:0];
          m_q           <= hv[63] ? 64'(-hv) : 64'(hv);
          cnt_q         <= '0;
          noise_q[ch_q] <= xorshift(noise_q[ch_q]);
        end
        ST_NORM: begin
          // scan for the leading one, a byte at a time, then a bit at a time
          if (m_q == 64'd0) sh_q <= 7'd40;
          else if (m_q[63]) sh_q <= 7'd20 + 7'(cnt_q);
          else if (m_q[63:56] == 8'd0) begin
            m_q   <= m_q << 8;
            cnt_q <= cnt_q + 6'd8;
          end else begin
            m_q   <= m_q << 1;
            cnt_q <= cnt_q + 6'd1;
          end
        end
        ST_DMUL: begin
          p_q    <= 61'(r_mag) * 61'(DITHER_K);
          rneg_q <= r_dith[32];
        end
        ST_DOUT: begin
          if (!ch_q) begin
            left_res_q <= out_word;
            ch_q       <= 1'b1;
          end else if (!out_valid_q || out_ready_i) begin
            out_q.left_out  <= left_res_q;
            out_q.right_out <= out_word;
            ch_q            <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

FILE: sv/sbscd_mul.sv
module sbscd_mul import sbscd_pkg::*; #(
  parameter int IntW = 48
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam logic [63:0] MaxMag = (64'd1 << (IntW - 1)) - 64'd1;

  logic [63:0]  a_mag_q, b_mag_q;
  logic         neg_q;
  shsel_e       sh_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  word_t        res_q;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_pos;
  logic [127:0] shifted;
  logic [63:0]  clipped;

  always_comb begin
    a_half = cnt_q[1] ? a_mag_q[63:32] : a_mag_q[31:0];
    b_half = cnt_q[0] ? b_mag_q[63:32] : b_mag_q[31:0];
    pp     = a_half * b_half;
    unique case (cnt_q[1:0])
      2'd0:    pp_pos = {64'd0, pp};
      2'd3:    pp_pos = {pp, 64'd0};
      default: pp_pos = {32'd0, pp, 32'd0};
    endcase
    unique case (sh_q)
      SH15:    shifted = acc_q >> 15;
      SH30:    shifted = acc_q >> 30;
      SH31:    shifted = acc_q >> 31;
      SH44:    shifted = acc_q >> 44;
      default: shifted = acc_q;
    endcase
    clipped = (shifted > {64'd0, MaxMag}) ? MaxMag : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= 3'd0;
      a_mag_q <= '0;
      b_mag_q <= '0;
      neg_q   <= 1'b0;
      sh_q    <= SH44;
      acc_q   <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        a_mag_q <= req_i.a[63] ? 64'(-req_i.a) : 64'(req_i.a);
        b_mag_q <= req_i.b[63] ? 64'(-req_i.b) : 64'(req_i.b);
        neg_q   <= req_i.a[63] ^ req_i.b[63];
        sh_q    <= req_i.sh;
        acc_q   <= '0;
        cnt_q   <= 3'd0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == 3'd4) begin
          res_q  <= neg_q ? -$signed(clipped) : $signed(clipped);
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          acc_q <= acc_q + pp_pos;
          cnt_q <= cnt_q + 3'd1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

FILE: sv/sbscd_trim_div.sv
module sbscd_trim_div import sbscd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trim_req_t req_i,
  output trim_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    TP_IDLE = 3'b001,
    TP_SUM  = 3'b010,
    TP_DIV  = 3'b100
  } tphase_e;

  tphase_e     phase_q;
  logic [47:0] pa_q;
  logic [31:0] to_q;
  logic [15:0] ln_q;
  logic [15:0] len_q;
  logic [48:0] num_q;
  logic [15:0] rem_q;
  logic [5:0]  cnt_q;
  logic        done_q;

  logic [16:0] trial;
  logic        qbit;

  always_comb begin
    trial = {rem_q, num_q[48]};
    qbit  = (trial >= {1'b0, len_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= TP_IDLE;
      done_q  <= 1'b0;
      pa_q    <= '0;
      to_q    <= '0;
      ln_q    <= '0;
      len_q   <= 16'd1;
      num_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        TP_IDLE: begin
          if (req_i.go) begin
            pa_q    <= 48'(req_i.trim_from) * 48'(req_i.n);
            to_q    <= req_i.trim_to;
            ln_q    <= req_i.len - req_i.n;
            len_q   <= req_i.len;
            phase_q <= TP_SUM;
          end
        end
        TP_SUM: begin
          num_q   <= 49'(pa_q) + 49'(to_q) * 49'(ln_q);
          rem_q   <= '0;
          cnt_q   <= 6'd48;
          phase_q <= TP_DIV;
        end
        TP_DIV: begin
          rem_q <= qbit ? 16'(trial - {1'b0, len_q}) : trial[15:0];
          num_q <= {num_q[47:0], qbit};
          if (cnt_q == 6'd0) begin
            done_q  <= 1'b1;
            phase_q <= TP_IDLE;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: phase_q <= TP_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.trim = num_q[31:0];

endmodule

FILE: tb/sv/tb_stereo_bus_saturate_clip_dither_core.sv
`timescale 1ns / 100ps

module tb_stereo_bus_saturate_clip_dither_core;
  import sbscd_pkg::*;

  localparam int IW = 48;
  localparam logic signed [64:0] SAT_MAX = (65'sd1 <<< (IW - 1)) - 65'sd1;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic [31:0] HALF_PI_Q28 = 32'h1921FB54;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_beat_t out_beat_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  stereo_bus_saturate_clip_dither_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_beat_i,
    .out_valid_o, .out_ready_i, .out_beat_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Register shadow and processing state of the output stage
  logic [16:0] fader_q;
  logic [15:0] blk_len_q;
  logic        lpf_on_q;
  logic [30:0] a0_q;
  logic [31:0] b1_q, b2_q;
  logic [31:0] trim_from, trim_to;
  logic [15:0] ramp_left;
  logic [3:0]  clip_hold;
  logic signed [63:0] lpf_z1 [2];
  logic signed [63:0] lpf_z2 [2];
  logic signed [63:0] clip_mem [2];
  logic [31:0] noise_st [2];

  in_beat_t  pending_pairs [$];
  out_beat_t expected_pairs [$];
  int unsigned mismatches = 0;
  longint unsigned cycles = 0;
  bit calm = 1'b0;
  bit in_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;

  // Q4.44 constants from decimal fractions, rounded
  function automatic logic signed [63:0] dec8(input logic [63:0] n);
    return ((n / 64'd390625) << 36) + (((n % 64'd390625) << 36) + 64'd195312) / 64'd390625;
  endfunction

  function automatic logic signed [63:0] dec10(input logic [63:0] n);
    return ((n / 64'd9765625) << 34)
      + (((n % 64'd9765625) << 34) + 64'd4882812) / 64'd9765625;
  endfunction

  function automatic logic signed [63:0] recip(input logic [63:0] k);
    return ((64'd1 << 44) + k / 64'd2) / k;
  endfunction

  function automatic logic signed [63:0] clamp_int(input logic signed [64:0] v);
    if (v > SAT_MAX) return SAT_MAX[63:0];
    if (v < -SAT_MAX) return -SAT_MAX[63:0];
    return v[63:0];
  endfunction

  function automatic logic [63:0] magn(input logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  // Magnitude product, truncated toward zero, saturated to the internal width
  function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b, input int s);
    logic [127:0] p;
    logic signed [63:0] v;
    p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> s;
    v = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : p[63:0];
    if (a[63] != b[63]) v = -v;
    return clamp_int({v[63], v});
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clamp_int({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sine_poly(input logic signed [63:0] x);
    logic signed [63:0] t, s, c;
    t = fmul(x, x, 44);
    s = recip(64'd6227020800);
    for (int i = 1; i < 7; i++) begin
      case (i)
        1: c = -recip(64'd39916800);
        2: c = recip(64'd362880);
        3: c = -recip(64'd5040);
        4: c = recip(64'd120);
        5: c = -recip(64'd6);
        default: c = 64'sd1 <<< 44;
      endcase
      s = sadd(c, fmul(t, s, 44));
    end
    return fmul(x, s, 44);
  endfunction

  function automatic logic [31:0] xorshift32(input logic [31:0] r);
    r ^= r << 13;
    r ^= r >> 17;
    r ^= r << 5;
    return r;
  endfunction

  function automatic logic signed [31:0] bus_channel(input logic signed [31:0] raw,
                                                     input logic [31:0] trim, input int c);
    logic signed [63:0] v, o, y, d, rr, tot, a0, b1, b2, hp, ck_t;
    logic [63:0] m, p;
    logic [3:0] pos, neg;
    int bl, e, sh;
    hp = dec8(64'd157079633);
    ck_t = dec10(64'd9549925859);
    pos = 4'b0001 << (2 * c);
    neg = 4'b0010 << (2 * c);
    v = fmul({{32{raw[31]}}, raw}, {32'd0, trim}, 15);
    if (v > hp) v = hp;
    if (v < -hp) v = -hp;
    v = sine_poly(v);
    if (lpf_on_q) begin
      a0 = {33'd0, a0_q};
      b1 = {{32{b1_q[31]}}, b1_q};
      b2 = {{32{b2_q[31]}}, b2_q};
      o = sadd(fmul(v, a0, 30), lpf_z1[c]);
      lpf_z1[c] = sadd(sadd(fmul(v, a0 * 2, 30), -fmul(o, b1, 30)), lpf_z2[c]);
      lpf_z2[c] = sadd(fmul(v, a0, 30), -fmul(o, b2, 30));
      v = o;
    end
    v = fmul(v, {32'd0, trim}, 31);
    if (v > (64'sd4 <<< 44)) v = 64'sd4 <<< 44;
    if (v < -(64'sd4 <<< 44)) v = -(64'sd4 <<< 44);
    // Soft clipper: a flagged side relaxes the held value before the new test
    if (clip_hold & pos) begin
      if (v < clip_mem[c]) clip_mem[c] = sadd(dec8(64'd70582080), fmul(v, dec8(64'd26091480), 44));
      else clip_mem[c] = sadd(dec8(64'd24917170), fmul(clip_mem[c], dec8(64'd73908510), 44));
    end
    clip_hold &= ~pos;
    if (v > ck_t) begin
      clip_hold |= pos;
      v = sadd(dec8(64'd70582080), fmul(clip_mem[c], dec8(64'd26091480), 44));
    end
    if (clip_hold & neg) begin
      if (v > clip_mem[c]) clip_mem[c] = sadd(-dec8(64'd70582080), fmul(v, dec8(64'd26091480), 44));
      else clip_mem[c] = sadd(-dec8(64'd24917170), fmul(clip_mem[c], dec8(64'd73908510), 44));
    end
    clip_hold &= ~neg;
    if (v < -ck_t) begin
      clip_hold |= neg;
      v = sadd(-dec8(64'd70582080), fmul(clip_mem[c], dec8(64'd26091480), 44));
    end
    y = clip_mem[c];
    clip_mem[c] = v;
    // Dither scaled to the binary exponent of the delayed sample
    m = magn(y);
    bl = 0;
    while (m != 0) begin
      bl++;
      m >>= 1;
    end
    e = (bl != 0) ? bl - 44 : 0;
    noise_st[c] = xorshift32(noise_st[c]);
    rr = $signed({32'd0, noise_st[c]}) - 64'sh7fffffff;
    sh = 40 - e;
    d = 0;
    if (sh < 64) begin
      p = magn(rr) * 64'd490616394;
      d = p >> sh;
      if (rr < 0) d = -d;
    end
    tot = sadd(y, d) >>> 14;
    if (tot > 64'sh7FFFFFFF) tot = 64'sh7FFFFFFF;
    if (tot < -64'sh80000000) tot = -64'sh80000000;
    return tot[31:0];
  endfunction

  function automatic out_beat_t bus_stage_predict(input in_beat_t b);
    logic [63:0] len, n, f, trim;
    out_beat_t r;
    len = (blk_len_q == 0) ? 64'd1 : {48'd0, blk_len_q};
    if (ramp_left == 0) begin
      f = (fader_q > 17'd65536) ? 64'd65536 : {47'd0, fader_q};
      f <<= 16;
      trim_from = trim_to;
      trim_to = (f > 64'hFFFFFFFF) ? 32'hFFFFFFFF : f[31:0];
      ramp_left = len[15:0];
    end
    ramp_left = ramp_left - 16'd1;
    n = ({48'd0, ramp_left} > len) ? len : {48'd0, ramp_left};
    trim = ({32'd0, trim_from} * n + {32'd0, trim_to} * (len - n)) / len;
    r.left_out = bus_channel(b.left_in, trim[31:0], 0);
    r.right_out = bus_channel(b.right_in, trim[31:0], 1);
    return r;
  endfunction

  // Hold the beat until it is taken; open random gaps only between beats
  always @(negedge clk_i) begin
    logic nv;
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_pairs.size() > 0) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
        end else begin
          nv = 1'b1;
          in_beat_i <= pending_pairs.pop_front();
        end
      end
      in_valid_i <= nv;
    end
  end

  // Stall the output side in bursts
  always @(negedge clk_i) begin
    if (recv_stall > 0) begin
      recv_stall--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 14) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Predict on every accepted input beat, compare every accepted output beat
  always @(posedge clk_i) begin
    out_beat_t want;
    in_fire <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) expected_pairs.push_back(bus_stage_predict(in_beat_i));
    if (out_valid_o && out_ready_i) begin
      if (expected_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", out_beat_o);
      end else begin
        want = expected_pairs.pop_front();
        if (want.left_out !== out_beat_o.left_out || want.right_out !== out_beat_o.right_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pair mismatch: expected L %h R %h, got L %h R %h",
                     want.left_out, want.right_out, out_beat_o.left_out, out_beat_o.right_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("stereo_bus_saturate_clip_dither_core verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_FADER:  fader_q = val[16:0];
      CFG_BLOCK:  blk_len_q = val[15:0];
      CFG_FILTER: lpf_on_q = val[0];
      CFG_A0:     a0_q = val[30:0];
      CFG_B1:     b1_q = val;
      CFG_B2:     b2_q = val;
      CFG_SEED_L: noise_st[0] = val;
      default:    noise_st[1] = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued pair has been sent and answered
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid_i || expected_pairs.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h40000000) - 32'h20000000;
      3: return ($urandom_range(0, 1) ? HALF_PI_Q28 : -HALF_PI_Q28)
                + $urandom_range(0, 32'h01000000) - 32'h00800000;
      default: return $urandom_range(0, 32'h20000) - 32'h10000;
    endcase
  endfunction

  task automatic push_pair(input logic [31:0] l, input logic [31:0] r);
    in_beat_t b;
    b.left_in = l;
    b.right_in = r;
    pending_pairs.push_back(b);
  endtask

  function automatic logic [31:0] pick(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] rnd);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      default: return rnd;
    endcase
  endfunction

  initial begin
    // Reset values of the shadow state
    fader_q = 17'd32768; blk_len_q = 16'd64; lpf_on_q = 1'b0;
    a0_q = '0; b1_q = '0; b2_q = '0;
    trim_from = 32'h4000_0000; trim_to = 32'h4000_0000;
    ramp_left = '0; clip_hold = '0;
    lpf_z1 = '{0, 0}; lpf_z2 = '{0, 0}; clip_mem = '{0, 0};
    noise_st[0] = 32'd16386; noise_st[1] = 32'd24601;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and sine clamp while the trim ramps up from reset
    push_pair(32'h0, 32'h0);
    push_pair(32'h7FFFFFFF, 32'h80000000);
    push_pair(32'h80000000, 32'h7FFFFFFF);
    push_pair(32'h1, 32'hFFFFFFFF);
    push_pair(HALF_PI_Q28, -HALF_PI_Q28);
    push_pair(HALF_PI_Q28, -HALF_PI_Q28);
    push_pair(32'h10000000, 32'hF0000000);
    push_pair(32'h0, 32'h0);
    drain();

    // Fader over one, zero block length, filter on, zero seed
    cfg_write(CFG_FADER, 32'h1FFFF);
    cfg_write(CFG_BLOCK, 32'd0);
    cfg_write(CFG_FILTER, 32'd1);
    cfg_write(CFG_A0, 32'h7FFFFFFF);
    cfg_write(CFG_B1, 32'h80000000);
    cfg_write(CFG_B2, 32'h7FFFFFFF);
    cfg_write(CFG_SEED_L, 32'd0);
    cfg_write(CFG_SEED_R, 32'hFFFFFFFF);
    push_pair(32'h08000000, 32'hF8000000);
    push_pair(32'h7FFFFFFF, 32'h80000000);
    push_pair(32'h00001000, 32'hFFFFF000);
    drain();

    // Long block, then shorten it mid-block
    cfg_write(CFG_FILTER, 32'd0);
    cfg_write(CFG_FADER, 32'd0);
    cfg_write(CFG_BLOCK, 32'd65535);
    repeat (4) push_pair(rand_sample(), rand_sample());
    drain();
    cfg_write(CFG_BLOCK, 32'd2);
    cfg_write(CFG_FADER, 32'd65536);
    repeat (4) push_pair(rand_sample(), rand_sample());
    drain();

    // Random phases over many register settings; the last one runs without idling
    for (int ph = 0; ph < 14; ph++) begin
      cfg_write(CFG_FADER, pick(32'd0, 32'd65536, $urandom_range(0, 32'h1FFFF)));
      cfg_write(CFG_BLOCK, pick(32'd1, 32'd65535,
                                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 12)));
      cfg_write(CFG_FILTER, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) begin
        // Plausible lowpass
        cfg_write(CFG_A0, $urandom_range(32'h00100000, 32'h08000000));
        cfg_write(CFG_B1, -$urandom_range(32'h40000000, 32'h7C000000));
        cfg_write(CFG_B2, $urandom_range(32'h10000000, 32'h38000000));
      end else begin
        cfg_write(CFG_A0, pick(32'd0, 32'h7FFFFFFF, $urandom));
        cfg_write(CFG_B1, pick(32'h80000000, 32'h7FFFFFFF, $urandom));
        cfg_write(CFG_B2, pick(32'h80000000, 32'h7FFFFFFF, $urandom));
      end
      cfg_write(CFG_SEED_L, pick(32'd16386, 32'hFFFFFFFF, $urandom));
      cfg_write(CFG_SEED_R, pick(32'd0, 32'hFFFFFFFF, $urandom));
      if (ph == 13) calm = 1'b1;
      repeat (108) push_pair(rand_sample(), rand_sample());
      drain();
    end

    repeat (500) @(posedge clk_i);
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("stereo_bus_saturate_clip_dither_core verification clean");
    end else begin
      $display("stereo_bus_saturate_clip_dither_core verification failed");
    end
    $finish;
  end

endmodule

FILE: stereo_bus_saturate_clip_dither_core.f
sv/sbscd_pkg.sv
sv/sbscd_mul.sv
sv/sbscd_trim_div.sv
sv/stereo_bus_saturate_clip_dither_core.sv
tb/sv/tb_stereo_bus_saturate_clip_dither_core.sv
